### rtl/core/word_count_rle_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// word_count_rle_decoder_core_macros
// Assertion macros shared by the run-length decoder core.
// ----------------------------------------------------------------------------
`ifndef WORD_COUNT_RLE_DECODER_CORE_MACROS_SVH
`define WORD_COUNT_RLE_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// concurrent assertion, quiet while reset is held
`define WCRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent assertion, also checked while reset is held
`define WCRD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WCRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define WCRD_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/wcrd_pkg.sv
// ----------------------------------------------------------------------------
// wcrd_pkg
// Types and constants of the word-count run-length decoder core.
// ----------------------------------------------------------------------------
`default_nettype none

package wcrd_pkg;

  // image size limits and register reset values
  localparam int MAX_WIDTH    = 640;
  localparam int MAX_HEIGHT   = 480;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // field widths
  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 9;
  localparam int PIX_W    = 19;
  localparam int CNT_W    = 16;
  localparam int BYTE_W   = 8;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // record parsing phase, one-hot
  typedef enum logic [3:0] {
    PH_LOW     = 4'b0001,
    PH_HIGH    = 4'b0010,
    PH_REPEAT  = 4'b0100,
    PH_LITERAL = 4'b1000
  } phase_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_PIXELS = 2'd0,
    ST_DONE   = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  // image geometry as seen by the decoder
  typedef struct packed {
    logic [PIX_W-1:0] total;
    logic             ok;
  } cfg_t;

  // one decoded result
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [CNT_W-1:0]  run_length;
    logic [PIX_W-1:0]  start_offset;
    status_e           status;
    logic              end_flag;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/wcrd_cfg.sv
// ----------------------------------------------------------------------------
// wcrd_cfg
// Image size registers with the pixel total and range check kept alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module wcrd_cfg
  import wcrd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [WIDTH_W-1:0] cfg_data_i,
  output cfg_t                    cfg_o
);

  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [PIX_W-1:0]    total_q, total_d;
  logic                ok_q, ok_d;

  // next register values for a write
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    case (cfg_idx_e'(cfg_idx_i))
      CFG_IMAGE_WIDTH:  width_d  = cfg_data_i;
      CFG_IMAGE_HEIGHT: height_d = cfg_data_i[HEIGHT_W-1:0];
      default: ;
    endcase
    total_d = PIX_W'(width_d) * PIX_W'(height_d);
    ok_d    = (width_d != '0) && (width_d <= WIDTH_W'(MAX_WIDTH)) &&
              (height_d != '0) && (height_d <= HEIGHT_W'(MAX_HEIGHT));
  end

  // registers, total and check updated with the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(RESET_WIDTH);
      height_q <= HEIGHT_W'(RESET_HEIGHT);
      total_q  <= PIX_W'(RESET_WIDTH * RESET_HEIGHT);
      ok_q     <= 1'b1;
    end else if (cfg_we_i) begin
      width_q  <= width_d;
      height_q <= height_d;
      total_q  <= total_d;
      ok_q     <= ok_d;
    end
  end

  assign cfg_o.total = total_q;
  assign cfg_o.ok    = ok_q;

endmodule

`default_nettype wire

### rtl/core/wcrd_dec.sv
// ----------------------------------------------------------------------------
// wcrd_dec
// Record parser: count bytes, repeat and literal runs, fill and error checks.
// ----------------------------------------------------------------------------
`default_nettype none

module wcrd_dec
  import wcrd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [BYTE_W-1:0] data_i,
  input  wire logic              last_i,
  input  wire cfg_t              cfg_i,
  output logic                   res_valid_o,
  output res_t                   res_o
);

  phase_e             phase_q, phase_d;
  logic [BYTE_W-1:0]  low_q, low_d;
  logic [CNT_W-1:0]   pend_q, pend_d;
  logic [PIX_W-1:0]   pw_q, pw_d;
  logic               err_q, err_d;

  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [CNT_W-1:0]   cnt_len;
  logic [PIX_W:0]     total_x;
  logic [PIX_W:0]     hi_sum;
  logic [PIX_W:0]     rep_sum;
  logic [CNT_W-1:0]   lit_len;
  logic [PIX_W-1:0]   lit_sum;
  logic               fail;
  logic               clear;

  // count decode and run arithmetic
  always_comb begin
    cnt     = {data_i, low_q};
    neg     = (cnt == '0) || cnt[CNT_W-1];
    cnt_len = neg ? (CNT_W'(0) - cnt) : cnt;
    total_x = {1'b0, cfg_i.total};
    hi_sum  = {1'b0, pw_q} + (PIX_W+1)'(cnt_len);
    rep_sum = {1'b0, pw_q} + (PIX_W+1)'(pend_q);
    lit_len = (pend_q != '0) ? (pend_q - CNT_W'(1)) : '0;
    lit_sum = pw_q + PIX_W'(1);
  end

  // per-byte next state and result
  always_comb begin
    phase_d     = phase_q;
    low_d       = low_q;
    pend_d      = pend_q;
    pw_d        = pw_q;
    err_d       = err_q;
    fail        = 1'b0;
    clear       = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{pixel_value: '0, run_length: '0, start_offset: pw_q,
                    status: ST_PIXELS, end_flag: 1'b0};
    if (step_i) begin
      if (err_q) begin
        // discard until the body ends
        clear = last_i;
      end else if (!cfg_i.ok) begin
        fail = 1'b1;
      end else begin
        case (phase_q)
          PH_LOW: begin
            if ((pw_q >= cfg_i.total) || last_i) begin
              fail = 1'b1;
            end else begin
              low_d   = data_i;
              phase_d = PH_HIGH;
            end
          end
          PH_HIGH: begin
            if (last_i || (hi_sum > total_x)) begin
              fail = 1'b1;
            end else begin
              pend_d  = cnt_len;
              phase_d = neg ? PH_REPEAT : PH_LITERAL;
            end
          end
          PH_REPEAT: begin
            if (last_i && (rep_sum != total_x)) begin
              fail = 1'b1;
            end else begin
              pw_d    = rep_sum[PIX_W-1:0];
              pend_d  = '0;
              phase_d = PH_LOW;
              res_o.pixel_value = (pend_q != '0) ? data_i : '0;
              res_o.run_length  = pend_q;
              if (last_i) begin
                res_valid_o    = 1'b1;
                res_o.status   = ST_DONE;
                res_o.end_flag = 1'b1;
                clear          = 1'b1;
              end else begin
                // a zero repeat gives no result
                res_valid_o = (pend_q != '0);
              end
            end
          end
          PH_LITERAL: begin
            if (last_i && ((lit_len != '0) || (lit_sum != cfg_i.total))) begin
              fail = 1'b1;
            end else begin
              pw_d   = lit_sum;
              pend_d = lit_len;
              if (lit_len == '0) begin
                phase_d = PH_LOW;
              end
              res_valid_o       = 1'b1;
              res_o.pixel_value = data_i;
              res_o.run_length  = CNT_W'(1);
              if (last_i) begin
                res_o.status   = ST_DONE;
                res_o.end_flag = 1'b1;
                clear          = 1'b1;
              end
            end
          end
          default: begin
            phase_d = PH_LOW;
          end
        endcase
      end
    end

    // error report
    if (fail) begin
      res_valid_o = 1'b1;
      res_o       = '{pixel_value: '0, run_length: '0, start_offset: pw_q,
                      status: ST_ERROR, end_flag: 1'b1};
      if (last_i) begin
        clear = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end

    // back to the start of an image
    if (clear) begin
      phase_d = PH_LOW;
      low_d   = '0;
      pend_d  = '0;
      pw_d    = '0;
      err_d   = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LOW;
      low_q   <= '0;
      pend_q  <= '0;
      pw_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      low_q   <= low_d;
      pend_q  <= pend_d;
      pw_q    <= pw_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/wcrd_out.sv
// ----------------------------------------------------------------------------
// wcrd_out
// Result register driving the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module wcrd_out
  import wcrd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire res_t        res_i,
  output logic             free_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // pixel_value, run_length, start_offset
  output logic [1:0]       m_axis_tuser,   // status
  output logic             m_axis_tlast    // end_flag
);

  logic valid_q, valid_d;
  res_t res_q;

  // register is free when empty or being drained
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'b0, res_q.start_offset, res_q.run_length, res_q.pixel_value};
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tlast  = res_q.end_flag;

endmodule

`default_nettype wire

### rtl/core/word_count_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// word_count_rle_decoder_core
// Decodes a 16-bit count run-length image body into pixel runs.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata = data_byte, tlast = last_byte
//  m_axis    | out       | tdata = pixel_value/run_length/start_offset,
//            |           | tuser = status, tlast = end_flag
//  cfg       | in        | write only: image_width (0), image_height (1)
//
//  one byte per cycle sustained while m_axis is not stalled; a byte's result
//  passes from the input register through the parser into the result register
//  the parser advances whenever the result register is empty or drained,
//  so a stalled m_axis holds at most one byte in the input register
//  reset clears all control state at once; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_count_rle_decoder_core_macros.svh"

module word_count_rle_decoder_core
  import wcrd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // compressed body
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // data_byte
  input  wire logic               s_axis_tlast,   // last_byte
  // pixel runs
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [47:0]             m_axis_tdata,   // pixel_value, run_length, start_offset
  output logic [1:0]              m_axis_tuser,   // status
  output logic                    m_axis_tlast,   // end_flag
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [WIDTH_W-1:0] cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              out_free;
  logic              step;
  logic              res_valid;
  res_t              res;
  cfg_t              cfg;

  // input register
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_comb begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // image geometry
  wcrd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // record parser
  wcrd_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_i      (in_data_q),
    .last_i      (in_last_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  wcrd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step && res_valid),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // checks
  `WCRD_ASSERT(a_end_matches_status, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != ST_PIXELS)), "end flag and status disagree")
  `WCRD_ASSERT(a_error_no_pixels, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser == ST_ERROR)) |-> (m_axis_tdata[23:8] == 16'd0), "error result carries pixels")
  `WCRD_ASSERT(a_pixel_run_nonzero, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser == ST_PIXELS)) |-> (m_axis_tdata[23:8] != 16'd0), "empty pixel run reported")
  `WCRD_ASSERT_NR(a_no_result_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result shown during reset")

endmodule

`default_nettype wire
